[rtl/i2cbw_pkg.sv]
// ----------------------------------------------------------------------------
// i2cbw_pkg
// Shared types and constants for the I2C master byte writer: command and
// line-step payloads, queue entries and configuration register indexes.
// ----------------------------------------------------------------------------
package i2cbw_pkg;

  localparam int BITS_PER_BYTE = 8;
  localparam int BIT_IDX_W     = $clog2(BITS_PER_BYTE);
  localparam int BYTE_STEPS    = 3 * BITS_PER_BYTE + 2;
  localparam int STEP_W        = $clog2(BYTE_STEPS);
  localparam int HOLD_W        = 8;
  localparam int CFG_INDEX_W   = 2;
  localparam int CFG_DATA_W    = 8;

  // reset values of the hold registers
  localparam logic [HOLD_W-1:0] DATA_HOLD_RST       = 8'd5;
  localparam logic [HOLD_W-1:0] CLOCK_HIGH_HOLD_RST = 8'd10;
  localparam logic [HOLD_W-1:0] CLOCK_LOW_HOLD_RST  = 8'd5;

  // configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_DATA_HOLD       = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_CLOCK_HIGH_HOLD = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_CLOCK_LOW_HOLD  = 2'd2;

  // command kinds on the input channel
  typedef enum logic [1:0] {
    KIND_START = 2'd0,
    KIND_BYTE  = 2'd1,
    KIND_STOP  = 2'd2,
    KIND_ACK   = 2'd3
  } kind_t;

  // classified operation handed to the back end
  typedef enum logic [2:0] {
    OP_START  = 3'd0,
    OP_BYTE   = 3'd1,
    OP_STOP   = 3'd2,
    OP_ACK_HI = 3'd3,
    OP_ACK_LO = 3'd4,
    OP_ERROR  = 3'd5
  } op_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] byte_value;
    logic       sda_sample;
  } cmd_t;

  typedef struct packed {
    logic              scl_release;
    logic              sda_release;
    logic [HOLD_W-1:0] hold_time;
    logic              ack_wait;
    logic              order_error;
    logic              last_step;
  } step_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] byte_value;
    logic       err_scl;
    logic       err_sda;
    logic       err_wait;
  } qent_t;

endpackage

[rtl/i2cbw_queue.sv]
// ----------------------------------------------------------------------------
// i2cbw_queue
// Two-entry queue of classified commands between the front end and the
// line-step sequencer.
// ----------------------------------------------------------------------------
module i2cbw_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  i2cbw_pkg::qent_t  push_data,
  output logic              full,
  input  logic              pop,
  output i2cbw_pkg::qent_t  head,
  output logic              empty
);
  import i2cbw_pkg::*;

  qent_t       mem [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;

  assign full  = (count == 2'd2);
  assign empty = (count == 2'd0);
  assign head  = mem[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

[rtl/i2cbw_front.sv]
// ----------------------------------------------------------------------------
// i2cbw_front
// Command front end: checks the ack phase, classifies each command and
// tracks the bus line levels and ack phase at command granularity.
// ----------------------------------------------------------------------------
module i2cbw_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  i2cbw_pkg::cmd_t   in_data,
  input  logic              q_full,
  output logic              q_push,
  output i2cbw_pkg::qent_t  q_data
);
  import i2cbw_pkg::*;

  logic awaiting_ack;
  logic scl_line;
  logic sda_line;
  logic order_bad;
  kind_t kind;

  assign in_stall  = q_full;
  assign q_push    = in_valid && !q_full;
  assign kind      = kind_t'(in_data.kind);
  assign order_bad = (kind == KIND_ACK) != awaiting_ack;

  // classify the incoming command
  always_comb begin
    q_data            = '0;
    q_data.byte_value = in_data.byte_value;
    q_data.err_scl    = scl_line;
    q_data.err_sda    = sda_line;
    q_data.err_wait   = awaiting_ack;
    if (order_bad) begin
      q_data.op = OP_ERROR;
    end else begin
      case (kind)
        KIND_START: q_data.op = OP_START;
        KIND_BYTE:  q_data.op = OP_BYTE;
        KIND_STOP:  q_data.op = OP_STOP;
        default:    q_data.op = in_data.sda_sample ? OP_ACK_HI : OP_ACK_LO;
      endcase
    end
  end

  // line levels and ack phase as each accepted command will leave them
  always_ff @(posedge clk) begin
    if (rst) begin
      awaiting_ack <= 1'b0;
      scl_line     <= 1'b1;
      sda_line     <= 1'b1;
    end else if (q_push && !order_bad) begin
      case (kind)
        KIND_START: begin
          scl_line <= 1'b0;
          sda_line <= 1'b0;
        end
        KIND_BYTE: begin
          scl_line     <= 1'b1;
          sda_line     <= 1'b1;
          awaiting_ack <= 1'b1;
        end
        KIND_STOP: begin
          scl_line <= 1'b1;
          sda_line <= 1'b1;
        end
        default: begin
          scl_line <= in_data.sda_sample;
          if (!in_data.sda_sample) begin
            awaiting_ack <= 1'b0;
          end
        end
      endcase
    end
  end

endmodule

[rtl/i2cbw_back.sv]
// ----------------------------------------------------------------------------
// i2cbw_back
// Line-step sequencer: walks the queued command, one step per cycle unless
// stalled, into a registered output stage; holds the three hold registers.
// ----------------------------------------------------------------------------
module i2cbw_back (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_en,
  input  logic [i2cbw_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  logic [i2cbw_pkg::CFG_DATA_W-1:0]       cfg_data,
  input  logic                                   q_empty,
  input  i2cbw_pkg::qent_t                       q_head,
  output logic                                   q_pop,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output i2cbw_pkg::step_t                       out_data
);
  import i2cbw_pkg::*;

  logic [HOLD_W-1:0]    data_hold;
  logic [HOLD_W-1:0]    clock_high_hold;
  logic [HOLD_W-1:0]    clock_low_hold;
  logic                 scl_line;
  logic                 sda_line;
  logic [STEP_W-1:0]    cnt;
  logic [1:0]           ph;
  logic [BIT_IDX_W-1:0] bidx;
  logic                 fire;
  step_t                step;

  assign fire  = !q_empty && (!out_valid || !out_stall);
  assign q_pop = fire && step.last_step;

  // hold-time registers
  always_ff @(posedge clk) begin
    if (rst) begin
      data_hold       <= DATA_HOLD_RST;
      clock_high_hold <= CLOCK_HIGH_HOLD_RST;
      clock_low_hold  <= CLOCK_LOW_HOLD_RST;
    end else if (cfg_en) begin
      case (cfg_index)
        REG_DATA_HOLD:       data_hold       <= cfg_data;
        REG_CLOCK_HIGH_HOLD: clock_high_hold <= cfg_data;
        REG_CLOCK_LOW_HOLD:  clock_low_hold  <= cfg_data;
        default: ;
      endcase
    end
  end

  // line step for the current position in the command
  always_comb begin
    step             = '0;
    step.scl_release = scl_line;
    step.sda_release = sda_line;
    case (q_head.op)
      OP_START: begin
        case (cnt)
          STEP_W'(0): begin
            step.scl_release = 1'b1;
            step.hold_time   = clock_high_hold;
          end
          STEP_W'(1): begin
            step.sda_release = 1'b1;
            step.hold_time   = data_hold;
          end
          STEP_W'(2): begin
            step.sda_release = 1'b0;
            step.hold_time   = data_hold;
          end
          default: begin
            step.scl_release = 1'b0;
            step.hold_time   = clock_low_hold;
            step.last_step   = 1'b1;
          end
        endcase
      end
      OP_STOP: begin
        case (cnt)
          STEP_W'(0): begin
            step.sda_release = 1'b0;
            step.hold_time   = data_hold;
          end
          STEP_W'(1): begin
            step.scl_release = 1'b0;
            step.hold_time   = clock_low_hold;
          end
          STEP_W'(2): begin
            step.scl_release = 1'b1;
            step.hold_time   = clock_high_hold;
          end
          default: begin
            step.sda_release = 1'b1;
            step.hold_time   = data_hold;
            step.last_step   = 1'b1;
          end
        endcase
      end
      OP_BYTE: begin
        if (cnt == STEP_W'(BYTE_STEPS - 2)) begin
          // release sda for the ack bit
          step.sda_release = 1'b1;
        end else if (cnt == STEP_W'(BYTE_STEPS - 1)) begin
          step.scl_release = 1'b1;
          step.hold_time   = clock_high_hold;
          step.ack_wait    = 1'b1;
          step.last_step   = 1'b1;
        end else begin
          case (ph)
            2'd0: begin
              step.sda_release = q_head.byte_value[~bidx];
              step.hold_time   = data_hold;
            end
            2'd1: begin
              step.scl_release = 1'b1;
              step.hold_time   = clock_high_hold;
            end
            default: begin
              step.scl_release = 1'b0;
              step.hold_time   = clock_low_hold;
            end
          endcase
        end
      end
      OP_ACK_HI: begin
        step.ack_wait = 1'b1;
        if (cnt == STEP_W'(0)) begin
          step.scl_release = 1'b0;
          step.hold_time   = clock_low_hold;
        end else begin
          step.scl_release = 1'b1;
          step.hold_time   = clock_high_hold;
          step.last_step   = 1'b1;
        end
      end
      OP_ACK_LO: begin
        step.scl_release = 1'b0;
        step.hold_time   = clock_low_hold;
        step.last_step   = 1'b1;
      end
      default: begin
        // rejected command: report current lines, no hold
        step.scl_release = q_head.err_scl;
        step.sda_release = q_head.err_sda;
        step.ack_wait    = q_head.err_wait;
        step.order_error = 1'b1;
        step.last_step   = 1'b1;
      end
    endcase
  end

  // step counters, line levels and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      scl_line  <= 1'b1;
      sda_line  <= 1'b1;
      cnt       <= '0;
      ph        <= 2'd0;
      bidx      <= '0;
    end else begin
      if (fire) begin
        out_valid <= 1'b1;
        scl_line  <= step.scl_release;
        sda_line  <= step.sda_release;
        if (step.last_step) begin
          cnt  <= '0;
          ph   <= 2'd0;
          bidx <= '0;
        end else begin
          cnt <= cnt + STEP_W'(1);
          if (ph == 2'd2) begin
            ph   <= 2'd0;
            bidx <= bidx + BIT_IDX_W'(1);
          end else begin
            ph <= ph + 2'd1;
          end
        end
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_data <= step;
    end
  end

endmodule

[rtl/i2c_master_byte_writer.sv]
// ----------------------------------------------------------------------------
// i2c_master_byte_writer
// Write-only I2C master sequencer: turns start, send byte, stop and ack
// sample commands into timed SCL/SDA line steps.
// ----------------------------------------------------------------------------
// Usage:
//   Commands enter on in_valid/in_stall/in_data; each accepted command yields
//   a run of line steps on out_valid/out_stall/out_data, the last one marked
//   by last_step. Step counts: start 4, stop 4, send byte 26, ack sample 2
//   (high) or 1 (low); a command out of ack phase gives one step flagged
//   order_error and changes nothing.
//   The front end classifies a command in the cycle it is accepted and puts
//   it in a two-entry queue; the sequencer emits one step per cycle unless
//   the output stalls, so the first step passes through the queue and then
//   the output step register, and the sequencer's step counts set the rate.
//   A stall on the output freezes the step register and the sequencer; the
//   input keeps taking commands until the queue holds two.
//   Hold times come from cfg_en/cfg_index/cfg_data (data, clock high, clock low
//   at 0, 1, 2); the user must write them while idle, the block does not enforce it.
//   Reset (rst, synchronous) empties the queue, releases both lines, clears
//   the ack phase and loads hold times 5, 10 and 5.
// ----------------------------------------------------------------------------
module i2c_master_byte_writer (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  i2cbw_pkg::cmd_t                    in_data,
  output logic                               out_valid,
  input  logic                               out_stall,
  output i2cbw_pkg::step_t                   out_data,
  input  logic                               cfg_en,
  input  logic [i2cbw_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [i2cbw_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import i2cbw_pkg::*;

  qent_t q_data;
  qent_t q_head;
  logic  q_push;
  logic  q_pop;
  logic  q_full;
  logic  q_empty;

  // command front end
  i2cbw_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_data   (q_data)
  );

  // command queue
  i2cbw_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_data),
    .full      (q_full),
    .pop       (q_pop),
    .head      (q_head),
    .empty     (q_empty)
  );

  // line-step sequencer
  i2cbw_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_en    (cfg_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_empty   (q_empty),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

[rtl/i2cbw_checker.sv]
// ----------------------------------------------------------------------------
// i2cbw_checker
// Port-level checks for the I2C master byte writer, bound to the top level.
// ----------------------------------------------------------------------------
module i2cbw_checker (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_stall,
  input  logic                               out_valid,
  input  logic                               out_stall,
  input  i2cbw_pkg::step_t                   out_data
);
  import i2cbw_pkg::*;

  // a stalled step stays put
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("output step changed while stalled");

  // a rejected command is reported as a single step
  a_err_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.order_error |-> out_data.last_step)
    else $error("order error step not marked last");

  // a rejected command carries no hold time
  a_err_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.order_error |-> out_data.hold_time == '0)
    else $error("order error step has a hold time");

  // queue is not full and no step is out right after reset
  a_rst_ready: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !in_stall && !out_valid)
    else $error("not ready after reset");

endmodule

bind i2c_master_byte_writer i2cbw_checker u_chk (.*);
